// ----- rtl/ntse_pkg.sv -----
// Shared types, constants and helpers for the N-Triples string escaper.
package ntse_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 4;   // up to ten characters per byte

  localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_U_LO   = 7'h75;
  localparam logic [CHAR_W-1:0] CH_U_UP   = 7'h55;
  localparam logic [CHAR_W-1:0] CH_ERR    = 7'h00;

  localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h00020;
  localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h0007E;
  localparam logic [CP_W-1:0] CP_WIDE_LO  = 21'h10000;

  // Work handed from the decoder to the character sequencer for one byte.
  typedef struct packed {
    logic [1:0]       n_err;   // error results that come first
    logic             has_cp;  // a finished code point follows
    logic             print;   // printable ASCII, passed through
    logic             esc;     // printable but needs a backslash
    logic             wide;    // \U form with eight digits
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;     // total characters, zero for none
  } job_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 4'd10) c = 7'h30 + {3'b000, v};
    else           c = 7'h41 + {3'b000, v - 4'd10};
    return c;
  endfunction

endpackage

// ----- rtl/ntse_decode.sv -----
// UTF-8 decoder: keeps the sequence state and turns each byte into a job.
module ntse_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ntse_pkg::BYTE_W-1:0] byte_in,
  input  logic                        accept,
  output ntse_pkg::job_t              job
);
  import ntse_pkg::*;

  logic [CP_W-1:0] code_point_acc_r, code_point_acc_nxt;
  logic [1:0]      bytes_pending_r, bytes_pending_nxt;

  logic            s_err, s_cp;
  logic [CP_W-1:0] s_acc;
  logic [1:0]      s_pend;
  logic            second_bad;
  logic [CP_W-1:0] acc_sh;
  logic [1:0]      n_err;
  logic            has_cp;
  logic [CP_W-1:0] cp;
  logic            print, esc, wide;
  logic [LEN_W-1:0] cp_len;

  // Byte seen with the decoder idle.
  always_comb begin
    s_err  = 1'b0;
    s_cp   = 1'b0;
    s_acc  = '0;
    s_pend = 2'd0;
    if (byte_in == 8'h00) begin
      s_cp = 1'b0;
    end else if (!byte_in[7]) begin
      s_cp = 1'b1;
    end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
      s_acc  = {16'b0, byte_in[4:0]};
      s_pend = 2'd1;
    end else if (byte_in[7:4] == 4'hE) begin
      s_acc  = {17'b0, byte_in[3:0]};
      s_pend = 2'd2;
    end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
      s_acc  = {18'b0, byte_in[2:0]};
      s_pend = 2'd3;
    end else begin
      s_err = 1'b1;
    end
  end

  // Overlong, surrogate and out-of-range checks at the second byte.
  always_comb begin
    second_bad = 1'b0;
    if (bytes_pending_r == 2'd2 && code_point_acc_r < 21'h10) begin
      if (code_point_acc_r == 21'h0 && byte_in < 8'hA0) second_bad = 1'b1;
      if (code_point_acc_r == 21'hD && byte_in > 8'h9F) second_bad = 1'b1;
    end else if (bytes_pending_r == 2'd3) begin
      if (code_point_acc_r == 21'h0 && byte_in < 8'h90) second_bad = 1'b1;
      if (code_point_acc_r == 21'h4 && byte_in > 8'h8F) second_bad = 1'b1;
    end
  end

  assign acc_sh = {code_point_acc_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    n_err              = 2'd0;
    has_cp             = 1'b0;
    cp                 = {13'b0, byte_in};
    code_point_acc_nxt = code_point_acc_r;
    bytes_pending_nxt  = bytes_pending_r;
    if (bytes_pending_r == 2'd0) begin
      n_err              = {1'b0, s_err};
      has_cp             = s_cp;
      code_point_acc_nxt = s_acc;
      bytes_pending_nxt  = s_pend;
    end else if (byte_in == 8'h00) begin
      n_err              = 2'd1;
      code_point_acc_nxt = '0;
      bytes_pending_nxt  = 2'd0;
    end else if (byte_in[7:6] != 2'b10) begin
      // sequence cut short; the byte then starts over
      n_err              = 2'd1 + {1'b0, s_err};
      has_cp             = s_cp;
      code_point_acc_nxt = s_acc;
      bytes_pending_nxt  = s_pend;
    end else if (second_bad) begin
      n_err              = 2'd1;
      code_point_acc_nxt = '0;
      bytes_pending_nxt  = 2'd0;
    end else begin
      bytes_pending_nxt = bytes_pending_r - 2'd1;
      if (bytes_pending_r == 2'd1) begin
        has_cp             = 1'b1;
        cp                 = acc_sh;
        code_point_acc_nxt = '0;
      end else begin
        code_point_acc_nxt = acc_sh;
      end
    end
  end

  always_comb begin
    print = (cp >= CP_PRINT_LO) && (cp <= CP_PRINT_HI);
    esc   = print && (cp[CHAR_W-1:0] == CH_BSLASH || cp[CHAR_W-1:0] == CH_QUOTE);
    wide  = (cp >= CP_WIDE_LO);
    if (!has_cp)    cp_len = 4'd0;
    else if (print) cp_len = esc ? 4'd2 : 4'd1;
    else            cp_len = wide ? 4'd10 : 4'd6;
  end

  assign job.n_err  = n_err;
  assign job.has_cp = has_cp;
  assign job.print  = print;
  assign job.esc    = esc;
  assign job.wide   = wide;
  assign job.cp     = cp;
  assign job.len    = cp_len + {2'b00, n_err};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_point_acc_r <= '0;
      bytes_pending_r  <= 2'd0;
    end else if (accept) begin
      code_point_acc_r <= code_point_acc_nxt;
      bytes_pending_r  <= bytes_pending_nxt;
    end
  end

endmodule

// ----- rtl/ntse_emit.sv -----
// Character sequencer: holds one job and sends its characters through the output register.
module ntse_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ntse_pkg::job_t              job_in,
  input  logic                        job_load,
  output logic                        job_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ntse_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last,
  output logic                        out_bad
);
  import ntse_pkg::*;

  job_t             job_r;
  logic             job_vld_r;
  logic [LEN_W-1:0] step_r;
  logic             out_vld_r;
  logic [CHAR_W-1:0] char_r;
  logic             last_r, bad_r;

  logic             out_free, adv, fin;
  logic             is_err;
  logic [LEN_W-1:0] j;
  logic [2:0]       nib_idx;
  logic [31:0]      cp_ext;
  logic [3:0]       nib;
  logic [CHAR_W-1:0] ch;

  assign out_free = !out_vld_r || out_ready;
  assign adv      = job_vld_r && out_free;
  assign fin      = adv && (step_r == job_r.len - 4'd1);
  assign job_take = !job_vld_r || fin;

  assign is_err  = (step_r < {2'b00, job_r.n_err});
  assign j       = step_r - {2'b00, job_r.n_err};
  // digit position counted from the low nibble
  assign nib_idx = job_r.wide ? 3'(4'd9 - j) : 3'(4'd5 - j);
  assign cp_ext  = {11'b0, job_r.cp};
  assign nib     = cp_ext[nib_idx*4 +: 4];

  always_comb begin
    if (is_err) begin
      ch = CH_ERR;
    end else if (job_r.print) begin
      ch = (job_r.esc && j == 4'd0) ? CH_BSLASH : job_r.cp[CHAR_W-1:0];
    end else if (j == 4'd0) begin
      ch = CH_BSLASH;
    end else if (j == 4'd1) begin
      ch = job_r.wide ? CH_U_UP : CH_U_LO;
    end else begin
      ch = hex_char(nib);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      step_r    <= '0;
    end else if (job_load) begin
      job_vld_r <= (job_in.len != 4'd0);
      step_r    <= '0;
    end else if (fin) begin
      job_vld_r <= 1'b0;
    end else if (adv) begin
      step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) job_r <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // an error result is a run of its own
  always_ff @(posedge clk) begin
    if (adv) begin
      char_r <= ch;
      last_r <= is_err || (step_r == job_r.len - 4'd1);
      bad_r  <= is_err;
    end
  end

  assign out_valid = out_vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_bad   = bad_r;

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && bad_r |-> last_r && char_r == CH_ERR)
    else $error("error result not a lone zero character");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r |-> step_r < job_r.len)
    else $error("sequencer step beyond job length");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> job_take)
    else $error("job loaded while previous one still running");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fin && !job_load |=> !job_vld_r)
    else $error("job still marked busy after its last character");
`endif

endmodule

// ----- rtl/ntriples_string_escaper.sv -----
// N-Triples string escaper: UTF-8 bytes in, escaped ASCII characters out, one per
// transfer. Each input byte is decoded in the cycle it is taken and its characters
// (printable ASCII as is, backslash and quote with a backslash, other code points as
// \uXXXX or \UXXXXXXXX, malformed UTF-8 as one error result with tuser set and a zero
// character) leave through a single output register at one character per cycle while
// out_tready is high. The next byte waits while the k characters of a byte (k is 1 to
// 10) are sent; a byte that completes nothing, such as a lead byte, holds nothing up. The next
// byte is taken in the same cycle the last character of the previous one moves to
// the output register, so the output can stream without gaps. A zero byte ends the
// string and clears the decoder. tlast marks the last character of each run.
module ntriples_string_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // bad_utf8
);
  import ntse_pkg::*;

  job_t              job;
  logic              take;
  logic              accept;
  logic [CHAR_W-1:0] char_o;

  assign accept    = in_tvalid && take;
  assign in_tready = take;

  ntse_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (in_tdata),
    .accept  (accept),
    .job     (job)
  );

  ntse_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_in    (job),
    .job_load  (accept),
    .job_take  (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_o),
    .out_last  (out_tlast),
    .out_bad   (out_tuser)
  );

  assign out_tdata = {1'b0, char_o};

endmodule
